// ===== rtl/core/cset_pkg.sv =====
package cset_pkg;

    // Default sizes of the function table and the call stack
    localparam int NUM_FUNCS_DEF   = 128;
    localparam int STACK_DEPTH_DEF = 256;

    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    // Request kinds on the input tuser field (code 3 behaves as a read)
    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_END   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_OVERFLOW  = 3'd1;
    localparam logic [2:0] STAT_UNDERFLOW = 3'd2;
    localparam logic [2:0] STAT_MISMATCH  = 3'd3;
    localparam logic [2:0] STAT_BACKWARDS = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_CLEAR,
        SEQ_IDLE,
        SEQ_EXEC
    } seq_t;

    // One call stack frame
    typedef struct packed {
        logic [6:0]  func;
        logic [31:0] begin_ts;
        logic [31:0] child;
    } frame_t;

    localparam int FRAME_W = $bits(frame_t);

    // Stack update request from the sequencer
    typedef struct packed {
        logic        push;
        logic        pop;
        logic [6:0]  func;
        logic [31:0] begin_ts;
        logic [31:0] span;
    } stk_cmd_t;

    // Stack top view toward the sequencer
    typedef struct packed {
        logic        empty;
        logic        full;
        logic [6:0]  func;
        logic [31:0] begin_ts;
        logic [31:0] child;
    } stk_top_t;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? MAX32 : s[31:0];
    endfunction

endpackage

// ===== rtl/core/cset_ram.sv =====
module cset_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// ===== rtl/core/cset_stack.sv =====
module cset_stack #(
    parameter int STACK_DEPTH = cset_pkg::STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rd_en,
    input  cset_pkg::stk_cmd_t cmd,
    output cset_pkg::stk_top_t top
);
    import cset_pkg::*;

    localparam int SA = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);

    logic [DW-1:0] depth_reg, depth_next;
    frame_t        top_reg, top_next;
    frame_t        below;
    logic          mem_we;
    logic [DW-1:0] depth_m1;
    logic [DW-1:0] depth_m2;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);

    // Push spills the cached top to memory; pop reloads the frame below
    always_comb
    begin
        depth_next = depth_reg;
        top_next   = top_reg;
        mem_we     = 1'b0;
        if (cmd.push)
        begin
            mem_we     = (depth_reg != '0);
            top_next   = '{func: cmd.func, begin_ts: cmd.begin_ts, child: '0};
            depth_next = depth_reg + DW'(1);
        end
        else if (cmd.pop)
        begin
            top_next   = '{func: below.func, begin_ts: below.begin_ts,
                           child: sat_add(below.child, cmd.span)};
            depth_next = depth_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else
        begin
            depth_reg <= depth_next;
        end
    end

    // Hold the top frame in flops
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
    end

    cset_ram #(
        .WIDTH (FRAME_W),
        .DEPTH (STACK_DEPTH)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (depth_m1[SA-1:0]),
        .wdata (top_reg),
        .re    (rd_en),
        .raddr (depth_m2[SA-1:0]),
        .rdata (below)
    );

    assign top.empty    = (depth_reg == '0);
    assign top.full     = (depth_reg == DW'(STACK_DEPTH));
    assign top.func     = top_reg.func;
    assign top.begin_ts = top_reg.begin_ts;
    assign top.child    = top_reg.child;

endmodule

// ===== rtl/core/call_stack_exclusive_time.sv =====
// Channel  Direction  Contents
// s_axis   in         tuser: req_type; tdata: func_id, timestamp
// m_axis   out        tuser: status; tdata: owner_id, call_time, total_time
//
// Each event is accepted, then handled in the execute state: the accept cycle
// issues the total-table read, and for an end request the frame-below read;
// execute computes on the registered read data and writes back. After reset a
// clearing pass zeroes the total table; no event is accepted until it ends.
// The execute cycle waits while the output register holds a result not yet taken.
module call_stack_exclusive_time #(
    parameter int NUM_FUNCS   = cset_pkg::NUM_FUNCS_DEF,
    parameter int STACK_DEPTH = cset_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // func_id[6:0], timestamp[38:7], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // owner_id[6:0], call_time[38:7], total_time[70:39], pad
    output logic [2:0]  m_tuser    // status[2:0]
);
    import cset_pkg::*;

    localparam int FA = $clog2(NUM_FUNCS);

    seq_t          state_reg, state_next;
    logic [FA-1:0] clr_reg, clr_next;
    logic          clr_last;
    logic          accept;
    logic          exec_fire;
    logic          clr_en;

    stk_cmd_t      stk_cmd;
    stk_top_t      top;

    logic [6:0]    s_func_id;
    logic [31:0]   s_ts;
    logic [6:0]    tot_sel_id;
    logic [32:0]   span33;
    logic [31:0]   span;
    logic          back;
    logic          tot_ok;

    logic [1:0]    req_reg;
    logic [6:0]    id_reg;
    logic [31:0]   ts_reg;
    logic [31:0]   span_reg;
    logic          back_reg;
    logic          tot_ok_reg;

    logic [32:0]   excl33;
    logic          is_start, is_end, end_ok, push_ok;
    logic [31:0]   tot_rdata;
    logic [31:0]   total_sum;
    logic [2:0]    res_status;
    logic [6:0]    res_owner;
    logic [31:0]   res_call;
    logic [31:0]   res_total;

    logic          tot_we;
    logic [FA-1:0] tot_waddr;
    logic [31:0]   tot_wdata;

    logic          m_tvalid_reg;
    logic [71:0]   m_tdata_reg;
    logic [2:0]    m_tuser_reg;

    assign s_func_id = s_tdata[6:0];
    assign s_ts      = s_tdata[38:7];
    assign accept    = s_tvalid && s_tready;
    assign clr_last  = (clr_reg == FA'(NUM_FUNCS - 1));

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    state_next = SEQ_EXEC;
                end
            end
            SEQ_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready  = 1'b0;
        clr_en    = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            SEQ_CLEAR: clr_en    = 1'b1;
            SEQ_IDLE:  s_tready  = 1'b1;
            SEQ_EXEC:  exec_fire = !m_tvalid_reg || m_tready;
            default:   s_tready  = 1'b0;
        endcase
    end

    assign clr_next = clr_en ? clr_reg + FA'(1) : clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    // Accept cycle: pick the total to read and precompute the span
    assign tot_sel_id = (s_tuser == REQ_END && !top.empty) ? top.func : s_func_id;
    assign tot_ok     = ({25'b0, tot_sel_id} < 32'(NUM_FUNCS));
    assign span33     = {1'b0, s_ts} - {1'b0, top.begin_ts} + 33'd1;
    assign span       = span33[32] ? MAX32 : span33[31:0];
    assign back       = !top.empty && (s_ts < top.begin_ts);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg    <= s_tuser;
            id_reg     <= s_func_id;
            ts_reg     <= s_ts;
            span_reg   <= span;
            back_reg   <= back;
            tot_ok_reg <= tot_ok;
        end
    end

    // Execute cycle: classify the event and form the result
    assign is_start  = (req_reg == REQ_START);
    assign is_end    = (req_reg == REQ_END);
    assign excl33    = {1'b0, span_reg} - {1'b0, top.child};
    assign end_ok    = is_end && !top.empty && (top.func == id_reg) && !back_reg && !excl33[32];
    assign push_ok   = is_start && !top.full && !back_reg;
    assign total_sum = sat_add(tot_rdata, excl33[31:0]);

    always_comb
    begin
        res_status = STAT_OK;
        res_owner  = id_reg;
        priority if (is_start)
        begin
            if (top.full)
            begin
                res_status = STAT_OVERFLOW;
            end
            else if (back_reg)
            begin
                res_status = STAT_BACKWARDS;
            end
        end
        else if (is_end)
        begin
            if (top.empty)
            begin
                res_status = STAT_UNDERFLOW;
            end
            else
            begin
                res_owner = top.func;
                if (top.func != id_reg)
                begin
                    res_status = STAT_MISMATCH;
                end
                else if (back_reg || excl33[32])
                begin
                    res_status = STAT_BACKWARDS;
                end
            end
        end
        else
        begin
            res_status = STAT_OK;
        end
    end

    assign res_call  = end_ok ? excl33[31:0] : '0;
    assign res_total = !tot_ok_reg ? '0 : (end_ok ? total_sum : tot_rdata);

    // Stack update on a successful start or end
    assign stk_cmd.push     = exec_fire && push_ok;
    assign stk_cmd.pop      = exec_fire && end_ok;
    assign stk_cmd.func     = id_reg;
    assign stk_cmd.begin_ts = ts_reg;
    assign stk_cmd.span     = span_reg;

    cset_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (accept && s_tuser == REQ_END),
        .cmd   (stk_cmd),
        .top   (top)
    );

    // Total table write: clearing sweep, then accumulate on a closed call
    always_comb
    begin
        tot_we    = 1'b0;
        tot_waddr = clr_reg;
        tot_wdata = '0;
        if (clr_en)
        begin
            tot_we = 1'b1;
        end
        else if (exec_fire && end_ok && tot_ok_reg)
        begin
            tot_we    = 1'b1;
            tot_waddr = FA'(top.func);
            tot_wdata = total_sum;
        end
    end

    cset_ram #(
        .WIDTH (32),
        .DEPTH (NUM_FUNCS)
    ) u_total_ram (
        .clk   (clk),
        .we    (tot_we),
        .waddr (tot_waddr),
        .wdata (tot_wdata),
        .re    (accept),
        .raddr (FA'(tot_sel_id)),
        .rdata (tot_rdata)
    );

    // Output register: load on execute, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            m_tdata_reg <= {1'b0, res_total, res_call, res_owner};
            m_tuser_reg <= res_status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== verif/call_stack_exclusive_time_tb.sv =====
`timescale 1ns / 100ps

module call_stack_exclusive_time_tb;
    import cset_pkg::*;

    localparam int NUM_FUNCS   = NUM_FUNCS_DEF;
    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int EVENT_COUNT = 1225;
    localparam int IDLE_LIMIT  = 3000;

    // Spare request code, handled as a read
    localparam logic [1:0] REQ_SPARE = 2'd3;

    typedef struct {
        logic [1:0]  kind;
        logic [6:0]  id;
        logic [31:0] ts;
    } trace_event_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  owner;
        logic [31:0] call_time;
        logic [31:0] total;
    } profile_res_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;      // func_id[6:0], timestamp[38:7], zero pad
    logic [1:0]  s_tuser = REQ_READ; // req_type[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;           // owner_id[6:0], call_time[38:7], total_time[70:39], pad
    logic [2:0]  m_tuser;           // status[2:0]

    // Event traffic and results still owed by the block
    trace_event_t pending_events[$];
    profile_res_t results_due[$];
    int           n_fail = 0;
    int           n_events = 0;

    // Shadow of the profiler: call stack and per-function totals
    logic [6:0]   stk_func[STACK_DEPTH];
    logic [31:0]  stk_begin[STACK_DEPTH];
    logic [31:0]  stk_child[STACK_DEPTH];
    int unsigned  stk_depth;
    logic [31:0]  totals[NUM_FUNCS];

    // Stimulus side view of the stack, used to build well-formed traces
    logic [6:0]   open_ids[$];
    logic [31:0]  open_begins[$];
    logic [31:0]  trace_now;

    call_stack_exclusive_time #(
        .NUM_FUNCS  (NUM_FUNCS),
        .STACK_DEPTH(STACK_DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] clamp_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum > {1'b0, MAX32})
            return MAX32;
        return sum[31:0];
    endfunction

    // Apply one event to the shadow profiler and return the result it yields
    function automatic profile_res_t profile_event(input logic [1:0] kind,
                                                   input logic [6:0] id,
                                                   input logic [31:0] ts);
        profile_res_t r;
        int unsigned  top;
        logic [6:0]   fid;
        logic [32:0]  span_w;
        logic [31:0]  span;
        logic [31:0]  excl;
        r.status    = STAT_OK;
        r.owner     = id;
        r.call_time = 32'd0;
        r.total     = totals[id];
        if (kind == REQ_START)
        begin
            if (stk_depth >= STACK_DEPTH)
                r.status = STAT_OVERFLOW;
            else if (stk_depth > 0 && ts < stk_begin[stk_depth - 1])
                r.status = STAT_BACKWARDS;
            else
            begin
                stk_func[stk_depth]  = id;
                stk_begin[stk_depth] = ts;
                stk_child[stk_depth] = 32'd0;
                stk_depth++;
            end
        end
        else if (kind == REQ_END)
        begin
            if (stk_depth == 0)
                r.status = STAT_UNDERFLOW;
            else
            begin
                top     = stk_depth - 1;
                fid     = stk_func[top];
                r.owner = fid;
                r.total = totals[fid];
                if (fid != id)
                    r.status = STAT_MISMATCH;
                else if (ts < stk_begin[top])
                    r.status = STAT_BACKWARDS;
                else
                begin
                    span_w = {1'b0, ts} - {1'b0, stk_begin[top]} + 33'd1;
                    span   = span_w[32] ? MAX32 : span_w[31:0];
                    if (stk_child[top] > span)
                        r.status = STAT_BACKWARDS;
                    else
                    begin
                        // Pop, charge the parent with the span, credit the owner
                        excl      = span - stk_child[top];
                        stk_depth = top;
                        if (top > 0)
                            stk_child[top - 1] = clamp_add(stk_child[top - 1], span);
                        totals[fid] = clamp_add(totals[fid], excl);
                        r.call_time = excl;
                        r.total     = totals[fid];
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void flag_failure(input string msg);
        n_fail++;
        if (n_fail <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    task automatic add_event(input logic [1:0] kind, input logic [6:0] id, input logic [31:0] ts);
        trace_event_t e;
        e.kind = kind;
        e.id   = id;
        e.ts   = ts;
        pending_events.insert(pending_events.size(), e);
        n_events++;
    endtask

    // Advance trace time: mostly small steps, now and then a long one
    function automatic logic [31:0] next_tick();
        if ($urandom_range(0, 15) == 0)
            trace_now = trace_now + $urandom_range(1, 65536);
        else
            trace_now = trace_now + $urandom_range(1, 20);
        return trace_now;
    endfunction

    task automatic open_call(input logic [6:0] id);
        if (open_ids.size() == 0)
            trace_now = $urandom_range(0, 32'hF000_0000);
        else
            void'(next_tick());
        add_event(REQ_START, id, trace_now);
        open_ids.insert(open_ids.size(), id);
        open_begins.insert(open_begins.size(), trace_now);
    endtask

    task automatic close_call();
        add_event(REQ_END, open_ids[$], next_tick());
        void'(open_ids.pop_back());
        void'(open_begins.pop_back());
    endtask

    // Feed the input stream in bursts with random gaps
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        trace_event_t e;
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            s_tuser    <= REQ_READ;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                results_due.insert(results_due.size(),
                                   profile_event(s_tuser, s_tdata[6:0], s_tdata[38:7]));
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_events.size() > 0)
                begin
                    e = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= e.kind;
                    s_tdata  <= {1'b0, e.ts, e.id};
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Check each result transaction and stall the output on a mode pattern
    int stall_mode;
    int stall_left;

    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        profile_res_t want;
        profile_res_t got;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status    = m_tuser;
                got.owner     = m_tdata[6:0];
                got.call_time = m_tdata[38:7];
                got.total     = m_tdata[70:39];
                if (results_due.size() == 0)
                    flag_failure($sformatf("unexpected result st=%0d id=%0d call=%h tot=%h",
                                           got.status, got.owner, got.call_time, got.total));
                else
                begin
                    want = results_due.pop_front();
                    if (got.status != want.status || got.owner != want.owner ||
                        got.call_time != want.call_time || got.total != want.total)
                        flag_failure({$sformatf("mismatch exp st=%0d id=%0d call=%h tot=%h",
                                                want.status, want.owner, want.call_time,
                                                want.total),
                                      $sformatf(", got st=%0d id=%0d call=%h tot=%h",
                                                got.status, got.owner, got.call_time,
                                                got.total)});
                end
            end
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                stall_left = $urandom_range(1, 24);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= 1'b0;
            endcase
        end
    end

    // End the run when no transaction moves for too long
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stim_proc
        int        pick;
        bit        deep_done;
        logic [6:0] top_id;
        logic [31:0] top_begin;
        deep_done = 1'b0;
        stk_depth = 0;
        foreach (totals[i])
            totals[i] = 32'd0;

        // Empty table reads, unused request code, end on an empty stack
        add_event(REQ_READ, 7'd0, 32'd0);
        add_event(REQ_SPARE, 7'd127, MAX32);
        add_event(REQ_END, 7'd3, 32'd7);
        // Span wider than 32 bits, then a total already at its ceiling
        add_event(REQ_START, 7'd5, 32'd0);
        add_event(REQ_END, 7'd5, MAX32);
        add_event(REQ_START, 7'd5, 32'd0);
        add_event(REQ_END, 7'd5, 32'd10);
        // Parent child time driven to its ceiling, exclusive time of zero
        add_event(REQ_START, 7'd1, 32'd0);
        add_event(REQ_START, 7'd2, 32'd0);
        add_event(REQ_END, 7'd2, MAX32);
        add_event(REQ_START, 7'd3, 32'd0);
        add_event(REQ_END, 7'd3, 32'd5);
        add_event(REQ_END, 7'd1, MAX32);
        // Start before the top frame, child time beyond the span,
        // wrong id on end, end before the top frame
        add_event(REQ_START, 7'd127, 32'd100);
        add_event(REQ_START, 7'd0, 32'd99);
        add_event(REQ_START, 7'd0, 32'd100);
        add_event(REQ_END, 7'd0, 32'd200);
        add_event(REQ_END, 7'd127, 32'd150);
        add_event(REQ_END, 7'd64, 32'd300);
        add_event(REQ_END, 7'd127, 32'd99);
        add_event(REQ_END, 7'd127, 32'd300);
        add_event(REQ_READ, 7'd127, 32'hA5A5_5A5A);
        add_event(REQ_READ, 7'd0, 32'd0);

        while (n_events < EVENT_COUNT)
        begin
            // Once: fill the stack to the brim, overflow it, unwind
            if (!deep_done && n_events > 500)
            begin
                while (open_ids.size() > 0)
                    close_call();
                repeat (STACK_DEPTH)
                    open_call($urandom_range(0, 127));
                add_event(REQ_START, $urandom_range(0, 127), next_tick());
                while (open_ids.size() > 0)
                    close_call();
                deep_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (open_ids.size() > 0)
            begin
                top_id    = open_ids[$];
                top_begin = open_begins[$];
            end
            if (pick < 80)
            begin
                if (open_ids.size() == 0 ||
                    (open_ids.size() < 16 && $urandom_range(0, 99) < 50))
                    open_call($urandom_range(0, 127));
                else
                    close_call();
            end
            else if (pick < 85)
                add_event(REQ_READ, $urandom_range(0, 127), $urandom);
            else if (pick < 88)
                add_event(REQ_SPARE, $urandom_range(0, 127), $urandom);
            else if (pick < 93)
            begin
                // Wrong id, or an end with nothing open
                if (open_ids.size() > 0)
                    add_event(REQ_END, top_id ^ 7'($urandom_range(1, 127)), next_tick());
                else
                    add_event(REQ_END, $urandom_range(0, 127), $urandom);
            end
            else if (open_ids.size() > 0 && top_begin > 0)
            begin
                // Timestamp earlier than the top frame's begin
                if (pick < 97)
                    add_event(REQ_START, $urandom_range(0, 127),
                              $urandom_range(0, top_begin - 1));
                else
                    add_event(REQ_END, top_id, $urandom_range(0, top_begin - 1));
            end
            else
                add_event(REQ_READ, $urandom_range(0, 127), $urandom);
        end
        while (open_ids.size() > 0)
            close_call();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything sent, every result back, then a short tail
        while (pending_events.size() > 0 || s_tvalid || results_due.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (n_fail == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/cset_pkg.sv
rtl/core/cset_ram.sv
rtl/core/cset_stack.sv
rtl/core/call_stack_exclusive_time.sv
verif/call_stack_exclusive_time_tb.sv
